### rtl/stq_pkg.sv
// Package: shared types and constants of the sorted timer queue.
`timescale 1ns / 1ps
package stq_pkg;

  localparam int MAX_RESULTS = 16;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_EXPIRY = 2'd0,
    KIND_ACK    = 2'd1,
    KIND_IDLE   = 2'd2
  } kind_t;

endpackage

### rtl/stq_ifs.sv
// Interfaces: input and result channels of the sorted timer queue.
`timescale 1ns / 1ps
interface stq_in_if import stq_pkg::*; ();
  logic        valid;
  logic        ready;
  opcode_t     opcode;
  logic [23:0] relative_delay;
  logic [7:0]  timer_id;

  modport source (output valid, opcode, relative_delay, timer_id, input ready);
  modport sink   (input valid, opcode, relative_delay, timer_id, output ready);
endinterface

interface stq_out_if import stq_pkg::*; ();
  logic       valid;
  logic       ready;
  kind_t      kind;
  logic [7:0] expired_id;
  logic       queue_full;
  logic       last;

  modport source (output valid, kind, expired_id, queue_full, last, input ready);
  modport sink   (input valid, kind, expired_id, queue_full, last, output ready);
endinterface

### rtl/stq_mem.sv
// Entry store: due time and id per slot, one write and one registered read port.
`timescale 1ns / 1ps
module stq_mem #(
  parameter int DEPTH     = 16,
  parameter int TIME_BITS = 32,
  parameter int IDX_W     = 4
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic [TIME_BITS-1:0] wr_due,
  input  logic [7:0]           wr_id,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output logic [TIME_BITS-1:0] rd_due,
  output logic [7:0]           rd_id
);

  logic [TIME_BITS-1:0] due_mem [DEPTH];
  logic [7:0]           id_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      due_mem[wr_addr] <= wr_due;
      id_mem[wr_addr]  <= wr_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_due <= due_mem[rd_addr];
      rd_id  <= id_mem[rd_addr];
    end
  end

endmodule

### rtl/sorted_timer_queue_unit.sv
// Top level: sorted timer queue, ring of entries in memory with a sequencer.
// Sequence: a set scans to the insert point, then shifts the tail one slot per cycle and
//   is acknowledged; a tick reads entries from the head and sends an expiry beat for
//   each entry that has expired, or an idle beat when none has, while the receiver
//   keeps up.
// Throughput: one item at a time; a new item is taken once the last beat has left.
// Reset: time, entry count and ring head clear; entry memory is not cleared.
`timescale 1ns / 1ps
module sorted_timer_queue_unit import stq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 32
) (
  input logic      clk,
  input logic      rst_n,
  stq_in_if.sink   in_chan,
  stq_out_if.source out_chan
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = (TIME_BITS > 24) ? TIME_BITS : 24;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_SHIFT = 6'b000100,
    ST_PUT   = 6'b001000,
    ST_TRD   = 6'b010000,
    ST_TCHK  = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic                 out_busy_r, out_busy_nxt;
  logic                 cont_r, cont_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [TIME_BITS-1:0] due_r, due_nxt;
  logic [7:0]           id_r, id_nxt;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     pos_r, pos_nxt;
  logic [CNT_W-1:0]     k_r, k_nxt;
  logic                 avail_r, avail_nxt;
  logic                 pend_r, pend_nxt;
  logic [7:0]           pend_id_r, pend_id_nxt;
  kind_t                out_kind_r, out_kind_nxt;
  logic [7:0]           out_id_r, out_id_nxt;
  logic                 out_full_r, out_full_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 wr_en, rd_en;
  logic [IDX_W-1:0]     wr_addr, rd_addr;
  logic [TIME_BITS-1:0] wr_due, rd_due;
  logic [7:0]           wr_id, rd_id;
  logic [TIME_BITS-1:0] scan_diff, tick_diff;
  logic                 scan_le, tick_le;
  logic [SUM_W-1:0]     due_sum;
  logic                 in_acc, out_acc;

  // ring slot of a queue position; operands stay below twice the depth
  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] h,
                                            input logic [CNT_W-1:0] p);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(h) + (CNT_W+1)'(p);
    if (s >= (CNT_W+1)'(QUEUE_DEPTH)) s = s - (CNT_W+1)'(QUEUE_DEPTH);
    return s[IDX_W-1:0];
  endfunction

  stq_mem #(
    .DEPTH     (QUEUE_DEPTH),
    .TIME_BITS (TIME_BITS),
    .IDX_W     (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_due  (wr_due),
    .wr_id   (wr_id),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_due  (rd_due),
    .rd_id   (rd_id)
  );

  assign in_chan.ready       = (state_r == ST_IDLE) && !out_busy_r;
  assign out_chan.valid      = out_busy_r;
  assign out_chan.kind       = out_kind_r;
  assign out_chan.expired_id = out_id_r;
  assign out_chan.queue_full = out_full_r;
  assign out_chan.last       = out_last_r;

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_busy_r && out_chan.ready;

  // wrap-aware "reached": signed difference zero or negative
  assign scan_diff = rd_due - due_r;
  assign scan_le   = (scan_diff == '0) || scan_diff[TIME_BITS-1];
  assign tick_diff = rd_due - now_r;
  assign tick_le   = (tick_diff == '0) || tick_diff[TIME_BITS-1];
  assign due_sum   = SUM_W'(now_r) + SUM_W'(in_chan.relative_delay);

  always_comb begin
    state_nxt    = state_r;
    out_busy_nxt = out_busy_r;
    cont_nxt     = cont_r;
    now_nxt      = now_r;
    due_nxt      = due_r;
    id_nxt       = id_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    pos_nxt      = pos_r;
    k_nxt        = k_r;
    avail_nxt    = avail_r;
    pend_nxt     = pend_r;
    pend_id_nxt  = pend_id_r;
    out_kind_nxt = out_kind_r;
    out_id_nxt   = out_id_r;
    out_full_nxt = out_full_r;
    out_last_nxt = out_last_r;
    wr_en   = 1'b0;
    wr_addr = slot(head_r, pos_r);
    wr_due  = due_r;
    wr_id   = id_r;
    rd_en   = 1'b0;
    rd_addr = slot(head_r, pos_r);

    if (out_acc) begin
      out_busy_nxt = 1'b0;
      if (cont_r) state_nxt = ST_TRD;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.opcode == OP_SET) begin
            if (count_r == CNT_W'(QUEUE_DEPTH)) begin
              out_busy_nxt = 1'b1;
              cont_nxt     = 1'b0;
              out_kind_nxt = KIND_ACK;
              out_id_nxt   = '0;
              out_full_nxt = 1'b1;
              out_last_nxt = 1'b1;
            end else begin
              due_nxt = due_sum[TIME_BITS-1:0];
              id_nxt  = in_chan.timer_id;
              pos_nxt = '0;
              if (count_r == '0) begin
                state_nxt = ST_PUT;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = head_r;
                state_nxt = ST_SCAN;
              end
            end
          end else begin
            now_nxt   = now_r + TIME_BITS'(1);
            pos_nxt   = '0;
            pend_nxt  = 1'b0;
            state_nxt = ST_TRD;
          end
        end
      end
      ST_SCAN: begin
        if (scan_le) begin
          pos_nxt = pos_r + CNT_W'(1);
          if (pos_r + CNT_W'(1) == count_r) begin
            state_nxt = ST_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = slot(head_r, pos_r + CNT_W'(1));
          end
        end else begin
          k_nxt     = count_r;
          rd_en     = 1'b1;
          rd_addr   = slot(head_r, count_r - CNT_W'(1));
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        // read data is the entry at k-1; it moves up one slot
        wr_en   = 1'b1;
        wr_addr = slot(head_r, k_r);
        wr_due  = rd_due;
        wr_id   = rd_id;
        if (k_r - CNT_W'(1) == pos_r) begin
          state_nxt = ST_PUT;
        end else begin
          k_nxt   = k_r - CNT_W'(1);
          rd_en   = 1'b1;
          rd_addr = slot(head_r, k_r - CNT_W'(2));
        end
      end
      ST_PUT: begin
        wr_en        = 1'b1;
        count_nxt    = count_r + CNT_W'(1);
        out_busy_nxt = 1'b1;
        cont_nxt     = 1'b0;
        out_kind_nxt = KIND_ACK;
        out_id_nxt   = '0;
        out_full_nxt = 1'b0;
        out_last_nxt = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_TRD: begin
        if (!out_busy_r) begin
          avail_nxt = (pos_r < count_r) && (int'(pos_r) < MAX_RESULTS);
          rd_en     = 1'b1;
          state_nxt = ST_TCHK;
        end
      end
      ST_TCHK: begin
        // pending expiry goes out once we know whether another follows
        cont_nxt = 1'b0;
        if (pend_r) begin
          out_busy_nxt = 1'b1;
          out_kind_nxt = KIND_EXPIRY;
          out_id_nxt   = pend_id_r;
          out_full_nxt = 1'b0;
          out_last_nxt = !(avail_r && tick_le);
        end
        if (avail_r && tick_le) begin
          pend_nxt    = 1'b1;
          pend_id_nxt = rd_id;
          pos_nxt     = pos_r + CNT_W'(1);
          cont_nxt    = pend_r;
          state_nxt   = pend_r ? ST_IDLE : ST_TRD;
        end else begin
          if (!pend_r) begin
            out_busy_nxt = 1'b1;
            out_kind_nxt = KIND_IDLE;
            out_id_nxt   = '0;
            out_full_nxt = 1'b0;
            out_last_nxt = 1'b1;
          end
          head_nxt  = slot(head_r, pos_r);
          count_nxt = count_r - pos_r;
          pend_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      out_busy_r <= 1'b0;
      cont_r     <= 1'b0;
      now_r      <= '0;
      head_r     <= '0;
      count_r    <= '0;
      pend_r     <= 1'b0;
      avail_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_busy_r <= out_busy_nxt;
      cont_r     <= cont_nxt;
      now_r      <= now_nxt;
      head_r     <= head_nxt;
      count_r    <= count_nxt;
      pend_r     <= pend_nxt;
      avail_r    <= avail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    due_r      <= due_nxt;
    id_r       <= id_nxt;
    pos_r      <= pos_nxt;
    k_r        <= k_nxt;
    pend_id_r  <= pend_id_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_full_r <= out_full_nxt;
    out_last_r <= out_last_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !out_chan.valid && !cont_r)
    else $error("input taken while a beat is outstanding");

  a_full_ack_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.queue_full) |-> count_r == CNT_W'(QUEUE_DEPTH))
    else $error("full reported with room in the queue");

  a_cont_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && cont_r) |-> !out_chan.last && out_chan.kind == KIND_EXPIRY)
    else $error("last beat marked while more expiries follow");

endmodule

### tb/tb_stq_ifs.sv
// Testbench-side note: channel interfaces come from the RTL file; this file holds the scoreboard class.
`timescale 1ns / 1ps
package tb_stq_pkg;
  import stq_pkg::*;

  // Behavioural predictor of the timer queue plus the store of pending results.
  class timer_queue_board;
    localparam int DEPTH = 16;
    bit [31:0] now;
    bit [31:0] due_q[$];
    bit [7:0]  id_q[$];
    kind_t     exp_kind[$];
    bit [7:0]  exp_id[$];
    bit        exp_full[$];
    bit        exp_last[$];
    int        errors;

    function new();
      now = '0;
      errors = 0;
    endfunction

    // due not after ref: signed difference zero or negative
    function bit reached(bit [31:0] due, bit [31:0] ref_t);
      bit [31:0] d;
      d = due - ref_t;
      return (d == 0) || d[31];
    endfunction

    function void push_result(kind_t k, bit [7:0] id, bit full, bit lst);
      exp_kind.push_back(k);
      exp_id.push_back(id);
      exp_full.push_back(full);
      exp_last.push_back(lst);
    endfunction

    function void note_item(opcode_t op, bit [23:0] delay, bit [7:0] id);
      bit [31:0] due;
      int pos;
      int popped;
      if (op == OP_SET) begin
        if (due_q.size() >= DEPTH) begin
          push_result(KIND_ACK, 8'd0, 1'b1, 1'b1);
          return;
        end
        due = now + delay;
        pos = 0;
        while (pos < due_q.size() && reached(due_q[pos], due)) pos++;
        due_q.insert(pos, due);
        id_q.insert(pos, id);
        push_result(KIND_ACK, 8'd0, 1'b0, 1'b1);
      end else begin
        now = now + 1;
        popped = 0;
        while (due_q.size() > 0 && popped < MAX_RESULTS && reached(due_q[0], now)) begin
          push_result(KIND_EXPIRY, id_q[0], 1'b0, 1'b0);
          void'(due_q.pop_front());
          void'(id_q.pop_front());
          popped++;
        end
        if (popped == 0) push_result(KIND_IDLE, 8'd0, 1'b0, 1'b1);
        else exp_last[exp_last.size()-1] = 1'b1;
      end
    endfunction

    function void report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endfunction

    function void check_result(kind_t k, bit [7:0] id, bit full, bit lst);
      if (exp_kind.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind=%0d id=%0d", k, id));
        return;
      end
      if (k !== exp_kind[0])
        report_mismatch($sformatf("kind %0d, want %0d", k, exp_kind[0]));
      if (id !== exp_id[0])
        report_mismatch($sformatf("expired_id %0d, want %0d", id, exp_id[0]));
      if (full !== exp_full[0])
        report_mismatch($sformatf("queue_full %0b, want %0b", full, exp_full[0]));
      if (lst !== exp_last[0])
        report_mismatch($sformatf("last %0b, want %0b", lst, exp_last[0]));
      void'(exp_kind.pop_front());
      void'(exp_id.pop_front());
      void'(exp_full.pop_front());
      void'(exp_last.pop_front());
    endfunction

    function int pending();
      return exp_kind.size();
    endfunction

    function int occupancy();
      return due_q.size();
    endfunction
  endclass
endpackage

### tb/tb_top.sv
// Testbench top: drives timer sets and ticks, checks every result beat against a predictor.
`timescale 1ns / 1ps
module tb_top;
  import stq_pkg::*;
  import tb_stq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  int   cycles;
  int   src_idle_pct;
  int   snk_idle_pct;
  timer_queue_board board;

  stq_in_if  in_chan ();
  stq_out_if out_chan ();

  sorted_timer_queue_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.opcode = OP_TICK;
    in_chan.relative_delay = '0;
    in_chan.timer_id = '0;
    out_chan.ready = 1'b0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    board = new();
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end
  initial cycles = 0;

  // receiver: random stall, check on accepted beats
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      board.check_result(out_chan.kind, out_chan.expired_id, out_chan.queue_full,
                         out_chan.last);
    out_chan.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // valid stays high into the next item unless the sender idles
  task automatic send_item(opcode_t op, logic [23:0] delay, logic [7:0] id);
    while ($urandom_range(99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.opcode <= op;
    in_chan.relative_delay <= delay;
    in_chan.timer_id <= id;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    board.note_item(op, delay, id);
  endtask

  task automatic send_random();
    int r;
    logic [23:0] delay;
    r = $urandom_range(99);
    if (r < 45) begin
      // mostly short delays so entries expire within the run
      case ($urandom_range(5))
        0: delay = 24'($urandom);
        1: delay = 24'd0;
        2: delay = 24'hFFFFFF;
        default: delay = 24'($urandom_range(12));
      endcase
      send_item(OP_SET, delay, 8'($urandom));
    end else begin
      send_item(OP_TICK, 24'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int i;
    int phase;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle tick, zero delay, ties, max delay, fill to full, burst pop
    send_item(OP_TICK, 24'd0, 8'd0);
    send_item(OP_SET, 24'd0, 8'hFF);
    send_item(OP_TICK, 24'hFFFFFF, 8'hFF);
    send_item(OP_SET, 24'hFFFFFF, 8'h00);
    for (i = 0; i < 15; i++) send_item(OP_SET, 24'd2, 8'(i + 1));
    send_item(OP_SET, 24'd1, 8'hA5);
    send_item(OP_TICK, 24'd0, 8'd0);
    send_item(OP_TICK, 24'd0, 8'd0);
    send_item(OP_TICK, 24'd0, 8'd0);

    for (phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 75 : 0;
      snk_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 27 : 0;
      for (i = 0; i < 90; i++) begin
        // occasional fill burst of equal due times to hit full and multi-pop
        if ($urandom_range(39) == 0)
          while (board.occupancy() < 16) send_item(OP_SET, 24'd3, 8'($urandom));
        send_random();
      end
    end
    in_chan.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (board.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

### filelist.f
rtl/stq_pkg.sv
rtl/stq_ifs.sv
rtl/stq_mem.sv
rtl/sorted_timer_queue_unit.sv
tb/tb_stq_ifs.sv
tb/tb_top.sv
